// File: hdl/b64u_pkg.sv
// Shared constants and character mapping functions for the base64url codec.
// No dependencies; imported by base64url_codec.
package b64u_pkg;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

  // Decoded value is 6 bits; bit 6 flags a character outside the alphabet.
  localparam logic [6:0] CHAR_BAD = 7'h40;

  localparam int GROUP_W = 24;
  localparam int MAX_RES = 4;

  // 6-bit index to base64url character.
  function automatic logic [7:0] enc_char(input logic [5:0] idx);
    logic [7:0] wide;
    wide = {2'b00, idx};
    if (idx < 6'd26) begin
      return 8'h41 + wide;
    end else if (idx < 6'd52) begin
      return 8'h61 + wide - 8'd26;
    end else if (idx < 6'd62) begin
      return 8'h30 + wide - 8'd52;
    end else if (idx == 6'd62) begin
      return 8'h2D;
    end else begin
      return 8'h5F;
    end
  endfunction

  // Character to 6-bit value, or CHAR_BAD.
  function automatic logic [6:0] dec_value(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      return 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      return 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2D) begin
      return 7'd62;
    end else if (c == 8'h5F) begin
      return 7'd63;
    end else begin
      return CHAR_BAD;
    end
  endfunction

endpackage

// File: hdl/base64url_codec.sv
// Streaming base64url codec (no padding on output), encode or decode by mode.
// Depends on b64u_pkg for the alphabet mapping and mode codes.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   input   | in_valid, in_ready, in_byte, in_last  | in
//   output  | out_valid, out_ready, out_byte,       | out
//           | out_last, error                       |
//   config  | cfg_wen, cfg_wdata (mode)             | in
//
// Each input beat is processed in the cycle it is accepted; its 0 to 4 results
// land in a 4-entry result buffer that drains one beat per cycle while
// out_ready is high. A new input beat is taken when the buffer is empty or is
// handing out its final entry, so the result buffer drain sets the throughput
// of both encoding and decoding.
// A stalled output holds the buffer and blocks input while any entry is left.
// Synchronous reset clears mode, group state and the buffer.
module base64url_codec
  import b64u_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       error
);

  logic                 mode;
  logic [GROUP_W-1:0]   group_bits, group_bits_next;
  logic [1:0]           group_fill, group_fill_next;
  logic [1:0]           pad_marks, pad_marks_next;
  logic                 error_seen, error_seen_next;

  logic [7:0]           res_byte [MAX_RES];
  logic [2:0]           res_cnt;
  logic                 res_last;
  logic                 res_err;

  logic [7:0]           new_byte [MAX_RES];
  logic [2:0]           new_cnt;
  logic                 new_err;

  logic [2:0]           enc_count;
  logic [GROUP_W-1:0]   enc_gb, enc_sh;
  logic [6:0]           dec_val;
  logic [5:0]           dec_v;
  logic [1:0]           dec_pos, dec_pad;
  logic                 dec_err;
  logic [GROUP_W-1:0]   dec_gb;

  logic                 in_fire, out_fire;

  assign out_valid = (res_cnt != 3'd0);
  assign out_byte  = res_byte[0];
  assign out_last  = res_last && (res_cnt == 3'd1);
  assign error     = res_err;
  assign in_ready  = (res_cnt == 3'd0) || (res_cnt == 3'd1 && out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  always_comb begin
    // encode path
    enc_count = {1'b0, group_fill} + 3'd1;
    enc_gb    = {group_bits[15:0], in_byte};
    case (enc_count)
      3'd3:    enc_sh = enc_gb;
      3'd2:    enc_sh = {enc_gb[15:0], 8'h00};
      default: enc_sh = {enc_gb[7:0], 16'h0000};
    endcase

    // decode path: classify the character
    dec_pos = group_fill;
    dec_val = dec_value(in_byte);
    dec_v   = dec_val[5:0];
    dec_pad = pad_marks;
    dec_err = error_seen;
    if (!error_seen) begin
      if (in_byte == PAD_CHAR && dec_pos[1]) begin
        dec_pad = pad_marks | ((dec_pos == 2'd2) ? 2'b01 : 2'b10);
        dec_v   = 6'd0;
      end else if (dec_val[6]) begin
        dec_err = 1'b1;
      end else if (dec_pos == 2'd3 && pad_marks[0]) begin
        dec_err = 1'b1;
      end
      // lone trailing character
      if (!dec_err && in_last && dec_pos == 2'd0) begin
        dec_err = 1'b1;
      end
    end
    dec_gb = {group_bits[17:0], dec_v};

    for (int k = 0; k < MAX_RES; k++) begin
      new_byte[k] = 8'h00;
    end
    new_cnt         = 3'd0;
    new_err         = 1'b0;
    group_bits_next = group_bits;
    group_fill_next = group_fill;
    pad_marks_next  = pad_marks;
    error_seen_next = error_seen;

    if (mode == MODE_ENCODE) begin
      for (int k = 0; k < MAX_RES; k++) begin
        new_byte[k] = enc_char(enc_sh[GROUP_W-1-6*k -: 6]);
      end
      if (enc_count == 3'd3) begin
        new_cnt         = 3'd4;
        group_bits_next = '0;
        group_fill_next = 2'd0;
      end else if (in_last) begin
        new_cnt = enc_count + 3'd1;
      end else begin
        group_bits_next = enc_gb;
        group_fill_next = enc_count[1:0];
      end
    end else begin
      if (!dec_err) begin
        if (dec_pos == 2'd3) begin
          new_byte[0]     = dec_gb[23:16];
          new_byte[1]     = dec_pad[0] ? dec_gb[7:0] : dec_gb[15:8];
          new_byte[2]     = dec_gb[7:0];
          new_cnt         = 3'd1 + {2'b00, ~dec_pad[0]} + {2'b00, ~dec_pad[1]};
          group_bits_next = '0;
          group_fill_next = 2'd0;
          pad_marks_next  = 2'b00;
        end else if (in_last) begin
          if (dec_pos == 2'd1) begin
            new_byte[0] = dec_gb[11:4];
            new_cnt     = 3'd1;
          end else if (dec_pad[0]) begin
            new_byte[0] = dec_gb[17:10];
            new_cnt     = 3'd1;
          end else begin
            new_byte[0] = dec_gb[17:10];
            new_byte[1] = dec_gb[9:2];
            new_cnt     = 3'd2;
          end
        end else begin
          group_bits_next = dec_gb;
          group_fill_next = dec_pos + 2'd1;
          pad_marks_next  = dec_pad;
        end
      end else begin
        error_seen_next = 1'b1;
      end
      // report a sticky error as one last beat
      if (in_last && dec_err) begin
        new_byte[0] = 8'h00;
        new_cnt     = 3'd1;
        new_err     = 1'b1;
      end
    end

    // end of message drops all group state
    if (in_last) begin
      group_bits_next = '0;
      group_fill_next = 2'd0;
      pad_marks_next  = 2'b00;
      error_seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_ENCODE;
      group_bits <= '0;
      group_fill <= 2'd0;
      pad_marks  <= 2'b00;
      error_seen <= 1'b0;
      res_cnt    <= 3'd0;
      res_last   <= 1'b0;
      res_err    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        // a mode write abandons any message in progress
        mode       <= cfg_wdata;
        group_bits <= '0;
        group_fill <= 2'd0;
        pad_marks  <= 2'b00;
        error_seen <= 1'b0;
      end else if (in_fire) begin
        group_bits <= group_bits_next;
        group_fill <= group_fill_next;
        pad_marks  <= pad_marks_next;
        error_seen <= error_seen_next;
      end
      if (in_fire) begin
        res_cnt  <= new_cnt;
        res_last <= in_last;
        res_err  <= new_err;
      end else if (out_fire) begin
        res_cnt <= res_cnt - 3'd1;
      end
    end
  end

  // result payload: load on input beat, advance on output beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int k = 0; k < MAX_RES; k++) begin
        res_byte[k] <= new_byte[k];
      end
    end else if (out_fire) begin
      for (int k = 0; k < MAX_RES - 1; k++) begin
        res_byte[k] <= res_byte[k+1];
      end
      res_byte[MAX_RES-1] <= 8'h00;
    end
  end

endmodule

// File: hdl/b64u_checker.sv
// Port-level checks for base64url_codec, attached by the bind below.
// Sees only the top-level ports; no package needed.
module b64u_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       error
);

  // an error beat carries a zero byte and closes the message
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> out_last && out_byte == 8'h00)
    else $error("error beat without out_last or with nonzero byte");

  // input is only taken while the output side is free or draining
  a_in_gate: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid || out_ready)
    else $error("input taken while output is stalled");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(out_last) && $stable(error))
    else $error("stalled output beat changed");

endmodule

bind base64url_codec b64u_checker u_b64u_checker (.*);

// File: verif/testbench.sv
// Self-checking testbench for base64url_codec: directed and random messages in both
// modes, checked beat by beat against an in-bench model of the codec.
// Depends on b64u_pkg and the base64url_codec RTL.
module testbench;
  import b64u_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } codec_beat_t;

  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
  localparam int NOT_IN_ALPHABET = 64;
  localparam int SETTLE_CYCLES = 4;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wen;
  logic       cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       error;

  // Model state
  logic        model_mode;
  logic [23:0] grp_bits;
  logic [1:0]  grp_fill;
  logic [1:0]  pad_seen;
  logic        msg_bad;
  codec_beat_t pending_results[$];

  bit tx_idle;
  bit rx_idle;
  int hold_off;
  int fail_count;
  int items_sent;
  int messages_sent;
  int results_seen;
  int errors_seen;
  int mode_writes;

  base64url_codec dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .error     (error)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void model_clear();
    grp_bits = '0;
    grp_fill = '0;
    pad_seen = '0;
    msg_bad  = 1'b0;
  endfunction

  function automatic void push_result(logic [7:0] data, logic err);
    codec_beat_t beat;
    beat.data = data;
    beat.last = 1'b0;
    beat.err  = err;
    pending_results.push_back(beat);
  endfunction

  function automatic void mark_last();
    codec_beat_t tail;
    tail = pending_results.pop_back();
    tail.last = 1'b1;
    pending_results.push_back(tail);
  endfunction

  function automatic logic [7:0] alpha_char(logic [5:0] idx);
    return ALPHABET[8 * (63 - int'(idx)) +: 8];
  endfunction

  function automatic int alpha_index(logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (alpha_char(6'(i)) == c) return i;
    end
    return NOT_IN_ALPHABET;
  endfunction

  function automatic void model_encode_byte(logic [7:0] b, logic last);
    int          count;
    int          nchars;
    logic [23:0] bits;
    count = int'(grp_fill) + 1;
    grp_bits = {grp_bits[15:0], b};
    nchars = 0;
    bits = grp_bits;
    if (count == 3) begin
      nchars = 4;
    end else if (last) begin
      // left-align a short final group, zero fill below
      nchars = count + 1;
      bits = grp_bits << (8 * (3 - count));
    end
    for (int k = 0; k < nchars; k++) begin
      push_result(alpha_char(bits[18 - 6 * k +: 6]), 1'b0);
    end
    if (nchars > 0) begin
      grp_bits = '0;
      grp_fill = '0;
    end else begin
      grp_fill = 2'(count);
    end
    if (last) begin
      mark_last();
      model_clear();
    end
  endfunction

  function automatic void model_decode_char(logic [7:0] c, logic last);
    int          pos;
    int          val;
    logic [31:0] wide;
    pos = int'(grp_fill);
    val = alpha_index(c);
    if (!msg_bad) begin
      if (c == PAD_CHAR && pos >= 2) begin
        pad_seen[pos - 2] = 1'b1;
        val = 0;
      end else if (val == NOT_IN_ALPHABET) begin
        msg_bad = 1'b1;
      end else if (pos == 3 && pad_seen[0]) begin
        msg_bad = 1'b1;
      end
    end
    if (!msg_bad) begin
      grp_bits = {grp_bits[17:0], 6'(val)};
      if (pos == 3) begin
        push_result(grp_bits[23:16], 1'b0);
        if (!pad_seen[0]) push_result(grp_bits[15:8], 1'b0);
        if (!pad_seen[1]) push_result(grp_bits[7:0], 1'b0);
        grp_bits = '0;
        grp_fill = '0;
        pad_seen = '0;
      end else if (last) begin
        if (pos == 0) begin
          msg_bad = 1'b1;
        end else if (pos == 1 || pad_seen[0]) begin
          wide = {8'h00, grp_bits} << (6 * (3 - pos));
          push_result(wide[23:16], 1'b0);
        end else begin
          wide = {8'h00, grp_bits} << 6;
          push_result(wide[23:16], 1'b0);
          push_result(wide[15:8], 1'b0);
        end
      end else begin
        grp_fill = 2'(pos + 1);
      end
    end
    if (last) begin
      if (msg_bad) push_result(8'h00, 1'b1);
      mark_last();
      model_clear();
    end
  endfunction

  task automatic send_item(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (model_mode == MODE_ENCODE) begin
      model_encode_byte(b, last);
    end else begin
      model_decode_char(b, last);
    end
    items_sent++;
    if (last) messages_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], i == s.len() - 1);
    end
  endtask

  // Write the mode only once the block has drained.
  task automatic set_mode(input logic m);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_wen <= 1'b0;
    model_mode = m;
    model_clear();
    mode_writes++;
  endtask

  task automatic test_encode_directed();
    set_mode(MODE_ENCODE);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b1);
    // full group hitting the two symbol characters
    send_item(8'hFB, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hBF, 1'b1);
  endtask

  task automatic test_decode_directed();
    set_mode(MODE_DECODE);
    send_text("QUI=-_");   // padded group mid-message, then two-character end
    send_text("QQ==");
    send_text("Q");        // lone final character
    send_text("=");        // pad in position zero
    send_text("QQ=A");     // pad followed by a real character
    send_item("A", 1'b0);  // a good character, a bad one, then more input after the error
    send_item(8'hFF, 1'b0);
    send_item("B", 1'b1);
  endtask

  task automatic test_encode_random();
    int start;
    int len;
    set_mode(MODE_ENCODE);
    start = items_sent;
    while (items_sent - start < 30) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        send_item(8'($urandom_range(0, 255)), i == len - 1);
      end
    end
  endtask

  task automatic send_decode_message();
    int         groups;
    int         tail;
    int         len;
    bit         padded;
    logic [7:0] c;
    if ($urandom_range(0, 9) < 7) begin
      groups = $urandom_range(0, 2);
      tail = $urandom_range(0, 2);
      if (tail > 0) tail++;
      if (groups == 0 && tail == 0) tail = 2;
      padded = (tail != 0) && ($urandom_range(0, 3) == 0);
      len = 4 * groups + (padded ? 4 : tail);
      for (int i = 0; i < len; i++) begin
        c = (padded && i >= 4 * groups + tail) ? PAD_CHAR : alpha_char(6'($urandom_range(0, 63)));
        send_item(c, i == len - 1);
      end
    end else begin
      // noise: stray bytes and pads anywhere
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 3))
          0: c = 8'($urandom_range(0, 255));
          1: c = PAD_CHAR;
          default: c = alpha_char(6'($urandom_range(0, 63)));
        endcase
        send_item(c, i == len - 1);
      end
    end
  endtask

  task automatic test_decode_random();
    int start;
    set_mode(MODE_DECODE);
    start = items_sent;
    while (items_sent - start < 15) send_decode_message();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    while (items_sent - start < 35) send_decode_message();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Stall the output long enough that the result buffer fills and input stops.
  task automatic test_output_backpressure();
    set_mode(MODE_ENCODE);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_off = 60;
    for (int i = 0; i < 12; i++) begin
      send_item(8'($urandom_range(0, 255)), i == 11);
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin : result_checker
    int          stall;
    codec_beat_t want;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && out_valid === 1'b1 && out_ready === 1'b1) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("unexpected result beat: out_byte %02h out_last %0b error %0b",
                 out_byte, out_last, error);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_byte);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, out_last);
            fail_count++;
          end
          if (error !== want.err) begin
            $error("error: expected %0b, got %0b", want.err, error);
            fail_count++;
          end
          if (want.err) errors_seen++;
        end
        stall = rx_idle ? $urandom_range(0, 9) : 0;
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #(12 * 300000);
    $display("** base64url_codec: FAILED **");
    $finish;
  end

  initial begin
    int guard;
    rst       = 1'b1;
    cfg_wen   = 1'b0;
    cfg_wdata = 1'b0;
    in_valid  = 1'b0;
    in_byte   = 8'h00;
    in_last   = 1'b0;
    out_ready = 1'b0;
    tx_idle   = 1'b1;
    rx_idle   = 1'b1;
    hold_off  = 0;
    model_mode = MODE_ENCODE;
    model_clear();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_encode_directed();
    test_decode_directed();
    test_encode_random();
    test_decode_random();
    test_output_backpressure();

    in_valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES + 4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected result beats never arrived", pending_results.size());
      fail_count += pending_results.size();
    end

    $display("Ran %0d input beats in %0d messages over %0d mode writes;",
             items_sent, messages_sent, mode_writes);
    $display("checked %0d result beats, %0d of them error reports.",
             results_seen, errors_seen);
    if (fail_count == 0) begin
      $display("** base64url_codec: PASSED **");
    end else begin
      $display("** base64url_codec: FAILED **");
    end
    $finish;
  end

endmodule
